@@ hw/rtl/base32_sorted_block_codec_core_assert.svh @@
// Assertion macros shared by the codec RTL files
`ifndef BASE32_SORTED_BLOCK_CODEC_CORE_ASSERT_SVH
`define BASE32_SORTED_BLOCK_CODEC_CORE_ASSERT_SVH

// Check a property on the rising clock edge, skipped while reset is high
`define B32_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on the rising clock edge, also during reset
`define B32_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ hw/rtl/b32sbc_pkg.sv @@
// Package with types, codes and alphabet functions of the base32 block codec
package b32sbc_pkg;

   localparam int LANES        = 8;
   localparam int SYM_W        = 5;
   localparam int CHAR_W       = 8;
   localparam int DATA_W       = 64;
   localparam int BITS_W       = LANES * SYM_W;
   localparam int BLOCK_CNT_W  = 4;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;

   localparam logic [BLOCK_CNT_W-1:0] MAX_BLOCKS = 4'd12;
   localparam logic [BLOCK_CNT_W-1:0] BLOCK_CNT_SAT = 4'd15;

   typedef logic [1:0] mode_type;
   localparam mode_type MODE_ENCODE   = 2'd0;
   localparam mode_type MODE_DECODE   = 2'd1;
   localparam mode_type MODE_VALIDATE = 2'd2;

   typedef logic [1:0] status_type;
   localparam status_type STATUS_OK       = 2'd0;
   localparam status_type STATUS_INVALID  = 2'd1;
   localparam status_type STATUS_TOO_LONG = 2'd2;

   localparam logic [0:0] CSR_IDX_MODE = 1'b0;

   localparam logic [CHAR_W-1:0] CHAR_DIGIT_LO = 8'd51;
   localparam logic [CHAR_W-1:0] CHAR_DIGIT_HI = 8'd57;
   localparam logic [CHAR_W-1:0] CHAR_ALPHA_LO = 8'd65;
   localparam logic [CHAR_W-1:0] CHAR_ALPHA_HI = 8'd89;
   localparam logic [CHAR_W-1:0] ALPHA_OFFSET  = 8'd58;
   localparam logic [SYM_W-1:0]  DIGIT_COUNT   = 5'd7;

   typedef struct packed {
      logic [CHAR_W-1:0] char_code;
      logic [SYM_W-1:0]  sym;
      logic              bad;
   } lane_result_type;

   typedef struct packed {
      logic [DATA_W-1:0] data;
      logic              last;
      status_type        status;
   } rsp_type;

   function automatic logic [CHAR_W-1:0] sym_to_char(input logic [SYM_W-1:0] sym);
      logic [CHAR_W-1:0] wide;
      wide = {{(CHAR_W-SYM_W){1'b0}}, sym};
      if (sym < DIGIT_COUNT) begin
         return wide + CHAR_DIGIT_LO;
      end
      return wide + ALPHA_OFFSET;
   endfunction

   function automatic logic [SYM_W:0] char_to_sym(input logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] diff;
      diff = '0;
      if (c >= CHAR_DIGIT_LO && c <= CHAR_DIGIT_HI) begin
         diff = c - CHAR_DIGIT_LO;
         return {1'b0, diff[SYM_W-1:0]};
      end
      if (c >= CHAR_ALPHA_LO && c <= CHAR_ALPHA_HI) begin
         diff = c - ALPHA_OFFSET;
         return {1'b0, diff[SYM_W-1:0]};
      end
      return {1'b1, {SYM_W{1'b0}}};
   endfunction

endpackage

@@ hw/rtl/base32_sorted_block_codec_core.sv @@
// A result is registered in the output buffer before it is offered on rsp_valid.
// One block per cycle while req_ready is high; eight character lanes work on a block at once.
// A two-entry output buffer keeps req_ready high while one result waits on rsp_ready.
// Reset (synchronous, active high): mode returns to encode, identifier state clears,
// and the output buffer empties.
module base32_sorted_block_codec_core
   import b32sbc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [DATA_W-1:0]     req_block_data,
   input  logic                  req_last_block,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [DATA_W-1:0]     rsp_result_data,
   output logic                  rsp_result_last,
   output logic [1:0]            rsp_status,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   mode_type                    mode_ff, mode_in;
   logic                        csr_write;
   logic                        accept;
   lane_result_type [LANES-1:0] lanes;
   rsp_type                     merged;
   rsp_type                     rsp_out;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_prdata = (csr_paddr[CSR_ADDR_W-1] == CSR_IDX_MODE) ?
                       {{(CSR_DATA_W-2){1'b0}}, mode_ff} : '0;

   always_comb begin
      mode_in = mode_ff;
      if (csr_write && csr_paddr[CSR_ADDR_W-1] == CSR_IDX_MODE) begin
         mode_in = csr_pwdata[1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_ENCODE;
      end else begin
         mode_ff <= mode_in;
      end
   end

   assign accept = req_valid & req_ready;

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      b32sbc_lane u_lane (
         .enc_sym  (req_block_data[BITS_W-1-SYM_W*g -: SYM_W]),
         .dec_char (req_block_data[DATA_W-1-CHAR_W*g -: CHAR_W]),
         .lane_out (lanes[g])
      );
   end

   b32sbc_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .mode       (mode_ff),
      .last_block (req_last_block),
      .lanes      (lanes),
      .result     (merged)
   );

   b32sbc_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_data   (merged),
      .in_ready  (req_ready),
      .out_valid (rsp_valid),
      .out_data  (rsp_out),
      .out_ready (rsp_ready)
   );

   assign rsp_result_data = rsp_out.data;
   assign rsp_result_last = rsp_out.last;
   assign rsp_status      = rsp_out.status;

endmodule

@@ hw/rtl/b32sbc_lane.sv @@
// One character lane: symbol to character and character to symbol match
module b32sbc_lane
   import b32sbc_pkg::*;
(
   input  logic [SYM_W-1:0]  enc_sym,
   input  logic [CHAR_W-1:0] dec_char,
   output lane_result_type   lane_out
);

   logic [SYM_W:0] dec_match;

   assign dec_match          = char_to_sym(dec_char);
   assign lane_out.char_code = sym_to_char(enc_sym);
   assign lane_out.sym       = dec_match[SYM_W-1:0];
   assign lane_out.bad       = dec_match[SYM_W];

endmodule

@@ hw/rtl/b32sbc_merge.sv @@
// Merge of lane results, identifier state and status
module b32sbc_merge
   import b32sbc_pkg::*;
(
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              accept,
   input  mode_type                          mode,
   input  logic                              last_block,
   input  lane_result_type [LANES-1:0]       lanes,
   output rsp_type                           result
);

`include "base32_sorted_block_codec_core_assert.svh"

   logic                   invalid_seen_ff, invalid_seen_in;
   logic [BLOCK_CNT_W-1:0] blocks_seen_ff, blocks_seen_in;
   logic [DATA_W-1:0]      enc_text;
   logic [BITS_W-1:0]      dec_bits;
   logic                   any_bad;
   logic                   text_mode;
   logic                   too_long;
   logic                   invalid_now;

   always_comb begin
      enc_text = '0;
      dec_bits = '0;
      any_bad  = 1'b0;
      for (int i = 0; i < LANES; i++) begin
         enc_text[DATA_W-1-CHAR_W*i -: CHAR_W] = lanes[i].char_code;
         dec_bits[BITS_W-1-SYM_W*i -: SYM_W]   = lanes[i].sym;
         any_bad = any_bad | lanes[i].bad;
      end
   end

   assign text_mode   = (mode != MODE_ENCODE);
   assign too_long    = (blocks_seen_ff >= MAX_BLOCKS);
   assign invalid_now = invalid_seen_ff | (text_mode & any_bad);

   always_comb begin
      result.last = last_block;
      case (mode)
         MODE_ENCODE: result.data = enc_text;
         MODE_DECODE: result.data = {{(DATA_W-BITS_W){1'b0}}, dec_bits};
         default:     result.data = '0;
      endcase
      if (too_long) begin
         result.status = STATUS_TOO_LONG;
      end else if (invalid_now) begin
         result.status = STATUS_INVALID;
      end else begin
         result.status = STATUS_OK;
      end
   end

   always_comb begin
      invalid_seen_in = invalid_seen_ff;
      blocks_seen_in  = blocks_seen_ff;
      if (accept) begin
         if (last_block) begin
            invalid_seen_in = 1'b0;
            blocks_seen_in  = '0;
         end else begin
            invalid_seen_in = invalid_now;
            if (blocks_seen_ff != BLOCK_CNT_SAT) begin
               blocks_seen_in = blocks_seen_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         invalid_seen_ff <= 1'b0;
         blocks_seen_ff  <= '0;
      end else begin
         invalid_seen_ff <= invalid_seen_in;
         blocks_seen_ff  <= blocks_seen_in;
      end
   end

   `B32_ASSERT(a_clear_after_last, clock, reset,
      accept && last_block |=> blocks_seen_ff == '0 && !invalid_seen_ff,
      "identifier state not cleared after last block")
   `B32_ASSERT(a_invalid_from_text, clock, reset,
      $rose(invalid_seen_ff) |-> $past(mode) != MODE_ENCODE,
      "invalid flag raised by an encode transaction")
   `B32_ASSERT(a_status_code, clock, reset, result.status <= STATUS_TOO_LONG,
      "status outside the defined codes")

endmodule

@@ hw/rtl/b32sbc_skid.sv @@
// Two-entry output buffer for result transactions
module b32sbc_skid
   import b32sbc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  rsp_type in_data,
   output logic    in_ready,
   output logic    out_valid,
   output rsp_type out_data,
   input  logic    out_ready
);

`include "base32_sorted_block_codec_core_assert.svh"

   logic    main_valid_ff, main_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type main_ff, main_in;
   rsp_type skid_ff, skid_in;
   logic    drain;

   assign drain     = main_valid_ff & out_ready;
   assign in_ready  = ~skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (drain) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = in_valid;
            main_in       = in_data;
         end
      end else if (in_valid) begin
         if (main_valid_ff) begin
            skid_in       = in_data;
            skid_valid_in = 1'b1;
         end else begin
            main_in       = in_data;
            main_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   `B32_ASSERT_ALWAYS(a_skid_needs_main, clock, reset || !skid_valid_ff || main_valid_ff,
      "skid entry held without a main entry")
   `B32_ASSERT(a_skid_holds, clock, reset,
      skid_valid_ff && !out_ready |=> skid_valid_ff && $stable(skid_ff),
      "skid entry lost while output stalled")
   `B32_ASSERT(a_out_holds, clock, reset,
      out_valid && !out_ready |=> out_valid && $stable(out_data),
      "output transaction changed while stalled")

endmodule

@@ tb/base32_sorted_block_codec_core_test.sv @@
// Self-checking testbench for the sorted-alphabet base32 block codec core
`timescale 1ns / 1ps

module base32_sorted_block_codec_core_test;
   import b32sbc_pkg::*;

   localparam mode_type MODE_RESERVED = 2'd3;
   localparam logic [CSR_ADDR_W-1:0] MODE_ADDR = {CSR_IDX_MODE, 2'b00};
   localparam logic [255:0] SYMBOLS = "3456789ABCDEFGHIJKLMNOPQRSTUVWXY";
   localparam int RANDOM_ITEMS = 550;
   localparam int QUIET_ITEMS  = 60;
   localparam int HOLD_CYCLES  = 80;
   localparam int CYCLE_LIMIT  = 200000;

   typedef struct packed {
      mode_type          mode;
      logic [DATA_W-1:0] data;
      logic              last;
      logic              typed;
      rsp_type           want;
   } plan_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [DATA_W-1:0]     req_block_data;
   logic                  req_last_block;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [DATA_W-1:0]     rsp_result_data;
   logic                  rsp_result_last;
   logic [1:0]            rsp_status;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   mode_type               cur_mode;
   logic                   id_bad_char;
   logic [BLOCK_CNT_W-1:0] id_block_count;
   rsp_type                results_due [$];
   plan_row_type           plan [$];
   int                     mismatches = 0;
   int                     cycle_count = 0;
   int                     sink_stall_pct = 0;
   bit                     hold_off_req = 1'b0;
   bit                     quiet_tail = 1'b0;

   base32_sorted_block_codec_core dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic rsp_type predict_block_result(input logic [DATA_W-1:0] blk,
                                                    input logic end_of_id);
      rsp_type           r;
      logic [BITS_W-1:0] bits;
      logic [CHAR_W-1:0] ch;
      logic [SYM_W-1:0]  sym;
      logic              hit;
      logic              bad;
      r = '0;
      bits = '0;
      bad = 1'b0;
      for (int lane = 0; lane < LANES; lane++) begin
         if (cur_mode == MODE_ENCODE) begin
            sym = blk[BITS_W - SYM_W * (lane + 1) +: SYM_W];
            r.data = {r.data[DATA_W-CHAR_W-1:0], SYMBOLS[8 * (31 - sym) +: 8]};
         end else begin
            ch = blk[DATA_W - CHAR_W * (lane + 1) +: CHAR_W];
            hit = 1'b0;
            sym = '0;
            for (int s = 0; s < 32; s++) begin
               if (SYMBOLS[8 * (31 - s) +: 8] == ch) begin
                  hit = 1'b1;
                  sym = SYM_W'(s);
               end
            end
            bad = bad | !hit;
            bits = {bits[BITS_W-SYM_W-1:0], sym};
         end
      end
      if (cur_mode == MODE_DECODE) begin
         r.data = {{(DATA_W-BITS_W){1'b0}}, bits};
      end
      if (cur_mode != MODE_ENCODE && bad) begin
         id_bad_char = 1'b1;
      end
      if (id_block_count >= MAX_BLOCKS) begin
         r.status = STATUS_TOO_LONG;
      end else if (id_bad_char) begin
         r.status = STATUS_INVALID;
      end else begin
         r.status = STATUS_OK;
      end
      r.last = end_of_id;
      if (end_of_id) begin
         id_bad_char = 1'b0;
         id_block_count = '0;
      end else if (id_block_count != BLOCK_CNT_SAT) begin
         id_block_count = id_block_count + 1'b1;
      end
      return r;
   endfunction

   task automatic offer_block(input logic [DATA_W-1:0] blk, input logic end_of_id,
                              input logic typed, input rsp_type want, input int gap_pct);
      rsp_type predicted;
      if (!quiet_tail && $urandom_range(0, 99) < gap_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11) - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_block_data <= blk;
      req_last_block <= end_of_id;
      do @(posedge clock); while (!req_ready);
      predicted = predict_block_result(blk, end_of_id);
      results_due.push_back(typed ? want : predicted);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (results_due.size() != 0) @(posedge clock);
   endtask

   task automatic set_mode(input mode_type m);
      logic [CSR_DATA_W-1:0] got;
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= MODE_ADDR;
      csr_pwdata <= {{(CSR_DATA_W-2){1'b0}}, m};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      cur_mode = m;
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      got = csr_prdata;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (got !== {{(CSR_DATA_W-2){1'b0}}, m}) begin
         $display("%0t: mode readback expected %h got %h", $time, m, got);
         mismatches++;
      end
   endtask

   // result checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (results_due.size() == 0) begin
            $display("%0t: unexpected transaction data %h last %b status %0d", $time,
                     rsp_result_data, rsp_result_last, rsp_status);
            mismatches++;
         end else begin
            want = results_due.pop_front();
            if (rsp_result_data !== want.data) begin
               $display("%0t: result_data expected %h got %h", $time, want.data,
                        rsp_result_data);
               mismatches++;
            end
            if (rsp_result_last !== want.last) begin
               $display("%0t: result_last expected %b got %b", $time, want.last,
                        rsp_result_last);
               mismatches++;
            end
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d got %0d", $time, want.status, rsp_status);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // result receiver
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_off_req = 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 99) < sink_stall_pct) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 11) - 1) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      int                n_items;
      int                phase_no;
      int                phase_left;
      int                id_left;
      int                gap_pct;
      int                pick;
      logic [DATA_W-1:0] blk;
      logic [CHAR_W-1:0] ch;
      mode_type          next_mode;

      reset = 1'b1;
      req_valid = 1'b0;
      req_block_data = '0;
      req_last_block = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      cur_mode = MODE_ENCODE;
      id_bad_char = 1'b0;
      id_block_count = '0;

      plan.push_back('{MODE_ENCODE, 64'h0, 1'b1, 1'b1,
                       '{64'h3333_3333_3333_3333, 1'b1, STATUS_OK}});
      plan.push_back('{MODE_ENCODE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1,
                       '{64'h5959_5959_5959_5959, 1'b1, STATUS_OK}});
      plan.push_back('{MODE_ENCODE, 64'hFFFF_FF00_0000_0000, 1'b1, 1'b1,
                       '{64'h3333_3333_3333_3333, 1'b1, STATUS_OK}});
      plan.push_back('{MODE_DECODE, "33333333", 1'b1, 1'b1, '{64'h0, 1'b1, STATUS_OK}});
      plan.push_back('{MODE_DECODE, "YYYYYYYY", 1'b1, 1'b1,
                       '{64'h0000_00FF_FFFF_FFFF, 1'b1, STATUS_OK}});
      plan.push_back('{MODE_DECODE, "3456789A", 1'b0, 1'b0, '0});
      plan.push_back('{MODE_DECODE, "Z3333333", 1'b0, 1'b1, '{64'h0, 1'b0, STATUS_INVALID}});
      plan.push_back('{MODE_DECODE, "33333333", 1'b1, 1'b1, '{64'h0, 1'b1, STATUS_INVALID}});
      plan.push_back('{MODE_VALIDATE, "2:@Z3333", 1'b1, 1'b1,
                       '{64'h0, 1'b1, STATUS_INVALID}});
      plan.push_back('{MODE_VALIDATE, "ABCDEFGH", 1'b1, 1'b1, '{64'h0, 1'b1, STATUS_OK}});
      plan.push_back('{MODE_RESERVED, 64'h3333_3333_3333_3300, 1'b1, 1'b1,
                       '{64'h0, 1'b1, STATUS_INVALID}});
      plan.push_back('{MODE_RESERVED, "XY345678", 1'b1, 1'b1, '{64'h0, 1'b1, STATUS_OK}});
      // one identifier of thirteen blocks, switching to decode near its end
      plan.push_back('{MODE_ENCODE, 64'h0000_0000_0842_1084, 1'b0, 1'b0, '0});
      plan.push_back('{MODE_ENCODE, 64'h0000_0012_3456_789A, 1'b0, 1'b0, '0});
      plan.push_back('{MODE_ENCODE, 64'h0000_00F0_F0F0_F0F0, 1'b0, 1'b0, '0});
      plan.push_back('{MODE_ENCODE, 64'h0000_0080_0000_0001, 1'b0, 1'b0, '0});
      plan.push_back('{MODE_ENCODE, 64'hA5A5_A5A5_A5A5_A5A5, 1'b0, 1'b0, '0});
      plan.push_back('{MODE_ENCODE, 64'h0000_007F_FFFF_FFFE, 1'b0, 1'b0, '0});
      plan.push_back('{MODE_ENCODE, 64'h0000_0055_AA55_AA55, 1'b0, 1'b0, '0});
      plan.push_back('{MODE_ENCODE, 64'h0000_0001_0000_0000, 1'b0, 1'b0, '0});
      plan.push_back('{MODE_ENCODE, 64'h0000_00C3_3C0F_F00F, 1'b0, 1'b0, '0});
      plan.push_back('{MODE_ENCODE, 64'h1234_5678_9ABC_DEF0, 1'b0, 1'b0, '0});
      plan.push_back('{MODE_ENCODE, 64'h0000_0039_CE73_9CE7, 1'b0, 1'b0, '0});
      plan.push_back('{MODE_DECODE, "BAD!CHAR", 1'b0, 1'b0, '0});
      plan.push_back('{MODE_DECODE, "33333333", 1'b1, 1'b1, '{64'h0, 1'b1, STATUS_TOO_LONG}});

      repeat (5) @(negedge clock);
      reset <= 1'b0;

      gap_pct = 30;
      sink_stall_pct = 30;
      foreach (plan[k]) begin
         if (plan[k].mode != cur_mode) begin
            drain_results();
            set_mode(plan[k].mode);
         end
         offer_block(plan[k].data, plan[k].last, plan[k].typed, plan[k].want, gap_pct);
      end

      n_items = 0;
      phase_no = 0;
      phase_left = 0;
      id_left = 0;
      blk = '0;
      while (n_items < RANDOM_ITEMS) begin
         if (phase_left == 0) begin
            next_mode = (phase_no < 4) ? mode_type'(phase_no) : mode_type'($urandom_range(0, 3));
            drain_results();
            set_mode(next_mode);
            gap_pct = 20 * $urandom_range(0, 2);
            sink_stall_pct = 20 * $urandom_range(0, 2);
            phase_left = $urandom_range(15, 60);
            phase_no++;
         end
         if (id_left == 0) begin
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
               id_left = $urandom_range(1, 4);
            end else if (pick < 9) begin
               id_left = $urandom_range(5, 13);
            end else begin
               id_left = $urandom_range(14, 18);
            end
         end
         if (cur_mode == MODE_ENCODE || $urandom_range(0, 9) == 0) begin
            blk = {$urandom(), $urandom()};
         end else begin
            for (int lane = 0; lane < LANES; lane++) begin
               ch = SYMBOLS[8 * $urandom_range(0, 31) +: 8];
               if ($urandom_range(0, 39) == 0) begin
                  ch = CHAR_W'($urandom_range(0, 255));
               end
               blk = {blk[DATA_W-CHAR_W-1:0], ch};
            end
         end
         if (n_items == 200) begin
            hold_off_req = 1'b1;
            gap_pct = 0;
         end
         if (n_items == 350) begin
            drain_results();
         end
         if (n_items == RANDOM_ITEMS - QUIET_ITEMS) begin
            quiet_tail = 1'b1;
         end
         offer_block(blk, id_left == 1, 1'b0, '0, gap_pct);
         id_left--;
         phase_left--;
         n_items++;
      end

      drain_results();
      repeat (4) @(posedge clock);
      if (mismatches == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
